// ===== src/ctlr_pkg.sv =====
// Shared types, codes and helpers for the cache tag lookup and replacement unit.
`timescale 1ns / 1ps
`default_nettype none
package ctlr_pkg;

    localparam int TAG_W = 32;
    localparam int CNT_W = 16;
    localparam int LFSR_W = 16;

    localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

    // Configuration register indexes
    localparam logic [1:0] CFG_BLOCK_SIZE = 2'd0;
    localparam logic [1:0] CFG_SET_COUNT  = 2'd1;
    localparam logic [1:0] CFG_POLICY     = 2'd2;

    // Replacement policy codes
    localparam logic [1:0] POL_RANDOM = 2'd0;
    localparam logic [1:0] POL_FIFO   = 2'd1;
    localparam logic [1:0] POL_LFU    = 2'd2;
    localparam logic [1:0] POL_LRU    = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_MODW,
        ST_APPLY,
        ST_UPD,
        ST_DONE
    } state_t;

    // Saturating counter increment
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        r = (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
        return r;
    endfunction

    // One step of the right-shifting LFSR, x^16+x^14+x^13+x^11+1
    function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] l);
        logic b;
        b = l[0] ^ l[2] ^ l[3] ^ l[5];
        return {b, l[LFSR_W-1:1]};
    endfunction

endpackage
`default_nettype wire

// ===== src/ctlr_mod.sv =====
// Bit-serial remainder unit: 16-bit dividend modulo a narrow divisor.
`timescale 1ns / 1ps
`default_nettype none
module ctlr_mod #(
    parameter int W = 6
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            start,
    input  wire logic [ctlr_pkg::LFSR_W-1:0]     dividend,
    input  wire logic [W-1:0]                    divisor,
    output logic                                 done,
    output logic [W-1:0]                         rem
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [3:0]                    step_reg, step_next;
    logic [ctlr_pkg::LFSR_W-1:0]   dvd_reg, dvd_next;
    logic [W-1:0]                  rem_reg, rem_next;
    logic [W-1:0]                  div_reg, div_next;
    logic [W:0]                    trial;

    // Shift in one dividend bit a cycle, subtract when it fits
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        trial     = {rem_reg, dvd_reg[ctlr_pkg::LFSR_W-1]};
        if (start) begin
            busy_next = 1'b1;
            step_next = 4'd15;
            dvd_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, div_reg}) begin
                rem_next = W'(trial - {1'b0, div_reg});
            end else begin
                rem_next = W'(trial);
            end
            dvd_next  = dvd_reg << 1;
            step_next = step_reg - 4'd1;
            if (step_reg == 4'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        step_reg <= step_next;
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        div_reg  <= div_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule
`default_nettype wire

// ===== src/cache_tag_lookup_replacement_unit.sv =====
// Top level: set-associative tag lookup with selectable replacement policy.
`timescale 1ns / 1ps
`default_nettype none
// One access is handled at a time. The ways of the selected set are read from the tag
// and counter memories one way per cycle (ways = LINES >> set bits). A result reaches the
// output register from the done state; the next address is taken once the unit is back
// in idle. LRU accesses and FIFO misses then sweep the counters once more, and a
// random-policy eviction also waits for the serial remainder unit. While the previous
// result still waits in the output register, the finished access holds until that
// result is taken.
// Configuration writes are taken every cycle and must only be issued while idle.
module cache_tag_lookup_replacement_unit #(
    parameter int LINES = 32
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_address,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_hit,
    output logic [4:0]       m_set_index,
    output logic [4:0]       m_way_index,
    output logic             m_evicted,
    output logic [31:0]      m_block_number
);

    localparam int AW = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int WW = $clog2(LINES + 1);
    localparam int MAX_SB = (WW - 1 < 5) ? WW - 1 : 5;
    localparam logic [WW-1:0] LINES_W = WW'(LINES);
    localparam int CW = ctlr_pkg::CNT_W;
    localparam int TW = ctlr_pkg::TAG_W;

    ctlr_pkg::state_t state_reg, state_next;

    logic [2:0]   bsize_reg, bsize_next;
    logic [2:0]   scount_reg, scount_next;
    logic [1:0]   policy_reg, policy_next;

    logic [WW-1:0] rd_way_reg, rd_way_next;
    logic          pend_reg, pend_next;
    logic [WW-1:0] pend_way_reg, pend_way_next;
    logic [TW-1:0] blk_reg, blk_next;
    logic [4:0]    set_reg, set_next;
    logic [AW-1:0] base_reg, base_next;
    logic [WW-1:0] ways_reg, ways_next;
    logic          hit_reg, hit_next;
    logic [WW-1:0] hit_way_reg, hit_way_next;
    logic [CW-1:0] hit_cnt_reg, hit_cnt_next;
    logic          found_reg, found_next;
    logic [WW-1:0] free_way_reg, free_way_next;
    logic [WW-1:0] best_way_reg, best_way_next;
    logic [CW-1:0] best_cnt_reg, best_cnt_next;
    logic [WW-1:0] way_reg, way_next;
    logic [CW-1:0] fin_reg, fin_next;
    logic          evict_reg, evict_next;
    logic [15:0]   lfsr_reg, lfsr_next;

    logic          m_valid_reg, m_valid_next;
    logic          o_hit_reg, o_hit_next;
    logic [4:0]    o_set_reg, o_set_next;
    logic [4:0]    o_way_reg, o_way_next;
    logic          o_evict_reg, o_evict_next;
    logic [TW-1:0] o_blk_reg, o_blk_next;

    logic          valid_reg [LINES];

    logic [TW-1:0] tag_mem [LINES];
    logic [CW-1:0] cnt_mem [LINES];
    logic [TW-1:0] tag_q;
    logic [CW-1:0] cnt_q;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          tag_we;
    logic          cnt_we;
    logic [AW-1:0] wr_addr;
    logic [CW-1:0] cnt_wd;
    logic          valid_set;

    logic [WW:0]   rd_sum, pend_sum;
    logic [AW-1:0] pend_addr;
    logic [2:0]    s_eff;
    logic [WW-1:0] ways_in;
    logic [TW-1:0] blk_in;
    logic [4:0]    set_in;
    logic [WW+4:0] base_prod;
    logic [WW-1:0] final_way;
    logic          bulk;
    logic          mod_start;
    logic          mod_done;
    logic [WW-1:0] mod_rem;

    // Serial remainder for the random victim
    ctlr_mod #(
        .W (WW)
    ) u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (mod_start),
        .dividend (lfsr_reg),
        .divisor  (ways_reg),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    // Map the incoming address to block, set and way count
    always_comb begin
        blk_in = s_address >> bsize_reg;
        s_eff  = (scount_reg > 3'(MAX_SB)) ? 3'(MAX_SB) : scount_reg;
        ways_in = LINES_W >> s_eff;
        set_in  = blk_in[4:0] & 5'((6'd1 << s_eff) - 6'd1);
        base_prod = (WW+5)'(set_in) * (WW+5)'(ways_in);
    end

    assign rd_sum    = (WW+1)'(base_reg) + (WW+1)'(rd_way_reg);
    assign pend_sum  = (WW+1)'(base_reg) + (WW+1)'(pend_way_reg);
    assign pend_addr = pend_sum[AW-1:0];

    always_comb begin
        if (hit_reg) begin
            final_way = hit_way_reg;
        end else if (found_reg) begin
            final_way = free_way_reg;
        end else if (policy_reg == ctlr_pkg::POL_RANDOM) begin
            final_way = mod_rem;
        end else begin
            final_way = best_way_reg;
        end
    end

    // Sequencer: scan, decide, wait for the remainder, apply, update counters, deliver
    always_comb begin
        state_next    = state_reg;
        bsize_next    = bsize_reg;
        scount_next   = scount_reg;
        policy_next   = policy_reg;
        rd_way_next   = rd_way_reg;
        pend_next     = 1'b0;
        pend_way_next = rd_way_reg;
        blk_next      = blk_reg;
        set_next      = set_reg;
        base_next     = base_reg;
        ways_next     = ways_reg;
        hit_next      = hit_reg;
        hit_way_next  = hit_way_reg;
        hit_cnt_next  = hit_cnt_reg;
        found_next    = found_reg;
        free_way_next = free_way_reg;
        best_way_next = best_way_reg;
        best_cnt_next = best_cnt_reg;
        way_next      = way_reg;
        fin_next      = fin_reg;
        evict_next    = evict_reg;
        lfsr_next     = lfsr_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        o_hit_next    = o_hit_reg;
        o_set_next    = o_set_reg;
        o_way_next    = o_way_reg;
        o_evict_next  = o_evict_reg;
        o_blk_next    = o_blk_reg;
        rd_en     = 1'b0;
        rd_addr   = rd_sum[AW-1:0];
        tag_we    = 1'b0;
        cnt_we    = 1'b0;
        wr_addr   = pend_addr;
        cnt_wd    = fin_reg;
        valid_set = 1'b0;
        mod_start = 1'b0;
        bulk      = (policy_reg == ctlr_pkg::POL_LRU) ||
                    (policy_reg == ctlr_pkg::POL_FIFO && !hit_reg);

        // Take configuration writes
        if (cfg_valid) begin
            case (cfg_index)
                ctlr_pkg::CFG_BLOCK_SIZE: bsize_next  = cfg_data[2:0];
                ctlr_pkg::CFG_SET_COUNT:  scount_next = cfg_data[2:0];
                ctlr_pkg::CFG_POLICY:     policy_next = cfg_data[1:0];
                default: ;
            endcase
        end

        case (state_reg)
            ctlr_pkg::ST_IDLE: begin
                if (s_valid) begin
                    blk_next    = blk_in;
                    set_next    = set_in;
                    base_next   = base_prod[AW-1:0];
                    ways_next   = ways_in;
                    rd_way_next = '0;
                    hit_next    = 1'b0;
                    found_next  = 1'b0;
                    state_next  = ctlr_pkg::ST_SCAN;
                end
            end
            ctlr_pkg::ST_SCAN: begin
                // Issue one way read a cycle
                if (rd_way_reg < ways_reg) begin
                    rd_en         = 1'b1;
                    rd_way_next   = rd_way_reg + 1'b1;
                    pend_next     = 1'b1;
                    pend_way_next = rd_way_reg;
                end
                // Compare the way read last cycle
                if (pend_reg) begin
                    if (valid_reg[pend_addr] && tag_q == blk_reg && !hit_reg) begin
                        hit_next     = 1'b1;
                        hit_way_next = pend_way_reg;
                        hit_cnt_next = cnt_q;
                    end
                    if (!valid_reg[pend_addr] && !found_reg) begin
                        found_next    = 1'b1;
                        free_way_next = pend_way_reg;
                    end
                    if (pend_way_reg == '0 ||
                        (policy_reg == ctlr_pkg::POL_LFU && cnt_q < best_cnt_reg) ||
                        (policy_reg != ctlr_pkg::POL_LFU && cnt_q > best_cnt_reg)) begin
                        best_way_next = pend_way_reg;
                        best_cnt_next = cnt_q;
                    end
                    if (pend_way_reg == ways_reg - 1'b1) begin
                        state_next = ctlr_pkg::ST_DECIDE;
                    end
                end
            end
            ctlr_pkg::ST_DECIDE: begin
                if (!hit_reg && !found_reg && policy_reg == ctlr_pkg::POL_RANDOM) begin
                    mod_start  = 1'b1;
                    state_next = ctlr_pkg::ST_MODW;
                end else begin
                    state_next = ctlr_pkg::ST_APPLY;
                end
            end
            ctlr_pkg::ST_MODW: begin
                if (mod_done) begin
                    state_next = ctlr_pkg::ST_APPLY;
                end
            end
            ctlr_pkg::ST_APPLY: begin
                way_next   = final_way;
                evict_next = !hit_reg && !found_reg;
                if (hit_reg) begin
                    fin_next = (policy_reg == ctlr_pkg::POL_LFU) ?
                               ctlr_pkg::sat_inc(hit_cnt_reg) : '0;
                end else begin
                    fin_next = (policy_reg == ctlr_pkg::POL_LFU) ? CW'(1) : '0;
                end
                wr_addr = rd_sum[AW-1:0];
                if (!hit_reg) begin
                    wr_addr   = AW'((WW+1)'(base_reg) + (WW+1)'(final_way));
                    tag_we    = 1'b1;
                    valid_set = 1'b1;
                    if (!found_reg && policy_reg == ctlr_pkg::POL_RANDOM) begin
                        lfsr_next = ctlr_pkg::lfsr_step(lfsr_reg);
                    end
                end
                if (bulk) begin
                    rd_way_next = '0;
                    state_next  = ctlr_pkg::ST_UPD;
                end else begin
                    wr_addr = AW'((WW+1)'(base_reg) + (WW+1)'(final_way));
                    cnt_we  = !hit_reg || policy_reg == ctlr_pkg::POL_LFU;
                    cnt_wd  = fin_next;
                    state_next = ctlr_pkg::ST_DONE;
                end
            end
            ctlr_pkg::ST_UPD: begin
                // Read one counter a cycle, write back the one read before
                if (rd_way_reg < ways_reg) begin
                    rd_en         = 1'b1;
                    rd_way_next   = rd_way_reg + 1'b1;
                    pend_next     = 1'b1;
                    pend_way_next = rd_way_reg;
                end
                if (pend_reg) begin
                    wr_addr = pend_addr;
                    if (pend_way_reg == way_reg) begin
                        cnt_we = 1'b1;
                        cnt_wd = fin_reg;
                    end else begin
                        cnt_we = valid_reg[pend_addr];
                        cnt_wd = ctlr_pkg::sat_inc(cnt_q);
                    end
                    if (pend_way_reg == ways_reg - 1'b1) begin
                        state_next = ctlr_pkg::ST_DONE;
                    end
                end
            end
            ctlr_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    o_hit_next   = hit_reg;
                    o_set_next   = set_reg;
                    o_way_next   = 5'(way_reg);
                    o_evict_next = evict_reg;
                    o_blk_next   = blk_reg;
                    state_next   = ctlr_pkg::ST_IDLE;
                end
            end
            default: state_next = ctlr_pkg::ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ctlr_pkg::ST_IDLE;
            bsize_reg   <= 3'd0;
            scount_reg  <= 3'd0;
            policy_reg  <= ctlr_pkg::POL_FIFO;
            pend_reg    <= 1'b0;
            lfsr_reg    <= ctlr_pkg::LFSR_SEED;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < LINES; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else begin
            state_reg   <= state_next;
            bsize_reg   <= bsize_next;
            scount_reg  <= scount_next;
            policy_reg  <= policy_next;
            pend_reg    <= pend_next;
            lfsr_reg    <= lfsr_next;
            m_valid_reg <= m_valid_next;
            if (valid_set) begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        rd_way_reg   <= rd_way_next;
        pend_way_reg <= pend_way_next;
        blk_reg      <= blk_next;
        set_reg      <= set_next;
        base_reg     <= base_next;
        ways_reg     <= ways_next;
        hit_reg      <= hit_next;
        hit_way_reg  <= hit_way_next;
        hit_cnt_reg  <= hit_cnt_next;
        found_reg    <= found_next;
        free_way_reg <= free_way_next;
        best_way_reg <= best_way_next;
        best_cnt_reg <= best_cnt_next;
        way_reg      <= way_next;
        fin_reg      <= fin_next;
        evict_reg    <= evict_next;
        o_hit_reg    <= o_hit_next;
        o_set_reg    <= o_set_next;
        o_way_reg    <= o_way_next;
        o_evict_reg  <= o_evict_next;
        o_blk_reg    <= o_blk_next;
    end

    // Tag and counter memories, registered read
    always_ff @(posedge aclk) begin
        if (tag_we) begin
            tag_mem[wr_addr] <= blk_reg;
        end
        if (cnt_we) begin
            cnt_mem[wr_addr] <= cnt_wd;
        end
        if (rd_en) begin
            tag_q <= tag_mem[rd_addr];
            cnt_q <= cnt_mem[rd_addr];
        end
    end

    assign cfg_ready      = 1'b1;
    assign s_ready        = (state_reg == ctlr_pkg::ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_hit          = o_hit_reg;
    assign m_set_index    = o_set_reg;
    assign m_way_index    = o_way_reg;
    assign m_evicted      = o_evict_reg;
    assign m_block_number = o_blk_reg;

`ifndef NO_ASSERTIONS
    a_hit_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_hit && m_evicted))
        else $error("hit reported together with an eviction");

    a_lfsr_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        lfsr_reg != '0)
        else $error("random LFSR reached the all-zero lock-up state");

    a_mod_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        mod_done |-> state_reg == ctlr_pkg::ST_MODW)
        else $error("remainder unit finished outside its wait state");

    a_no_write_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ctlr_pkg::ST_IDLE |-> !tag_we && !cnt_we)
        else $error("memory written while no access is in progress");
`endif

endmodule
`default_nettype wire

// ===== tb/ctlr_checker.sv =====
// Checker for the cache tag lookup unit: predicts each lookup and compares its result.
`timescale 1ns / 1ps
module ctlr_checker #(
    parameter int LINES = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [31:0] s_address,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_hit,
    input  logic [4:0]  m_set_index,
    input  logic [4:0]  m_way_index,
    input  logic        m_evicted,
    input  logic [31:0] m_block_number,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic        hit;
        logic [4:0]  set_index;
        logic [4:0]  way_index;
        logic        evicted;
        logic [31:0] block_number;
    } lookup_t;

    logic [31:0]                 tags [LINES];
    logic                        valid_bits [LINES];
    logic [ctlr_pkg::CNT_W-1:0]  counters [LINES];
    logic [ctlr_pkg::LFSR_W-1:0] lfsr;
    logic [2:0]                  blk_shift;
    logic [2:0]                  set_bits;
    logic [1:0]                  pol;
    lookup_t                     expected_lookups [$];

    function automatic logic [ctlr_pkg::CNT_W-1:0] bump(
        input logic [ctlr_pkg::CNT_W-1:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    // Predict one lookup and update the shadow cache
    function automatic lookup_t predict_lookup(input logic [31:0] addr);
        lookup_t r;
        logic [31:0] blk;
        int s, ways, set, base, way;
        logic hit, found, ev, fb;
        blk = addr >> blk_shift;
        s = (set_bits > 5) ? 5 : set_bits;
        while (s > 0 && (LINES >> s) == 0) s--;
        ways = LINES >> s;
        set = blk & ((1 << s) - 1);
        base = set * ways;
        hit = 0; found = 0; ev = 0; way = 0;
        for (int w = 0; w < ways; w++)
            if (!hit && valid_bits[base+w] && tags[base+w] == blk) begin
                hit = 1;
                way = w;
            end
        if (hit) begin
            if (pol == ctlr_pkg::POL_LFU) begin
                counters[base+way] = bump(counters[base+way]);
            end else if (pol == ctlr_pkg::POL_LRU) begin
                for (int w = 0; w < ways; w++)
                    if (valid_bits[base+w]) counters[base+w] = bump(counters[base+w]);
                counters[base+way] = 0;
            end
        end else begin
            for (int w = 0; w < ways; w++)
                if (!found && !valid_bits[base+w]) begin
                    found = 1;
                    way = w;
                end
            if (!found) begin
                ev = 1;
                way = 0;
                if (pol == ctlr_pkg::POL_RANDOM) begin
                    way = lfsr % ways;
                    fb = lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5];
                    lfsr = {fb, lfsr[15:1]};
                end else if (pol == ctlr_pkg::POL_LFU) begin
                    for (int w = 1; w < ways; w++)
                        if (counters[base+w] < counters[base+way]) way = w;
                end else begin
                    for (int w = 1; w < ways; w++)
                        if (counters[base+w] > counters[base+way]) way = w;
                end
            end
            if (pol == ctlr_pkg::POL_FIFO || pol == ctlr_pkg::POL_LRU)
                for (int w = 0; w < ways; w++)
                    if (valid_bits[base+w]) counters[base+w] = bump(counters[base+w]);
            tags[base+way] = blk;
            valid_bits[base+way] = 1;
            counters[base+way] = (pol == ctlr_pkg::POL_LFU) ? 16'd1 : 16'd0;
        end
        r.hit = hit;
        r.set_index = set[4:0];
        r.way_index = way[4:0];
        r.evicted = ev;
        r.block_number = blk;
        return r;
    endfunction

    assign pending = expected_lookups.size();

    // Track register writes, predict on input transfers, compare on output transfers
    always @(posedge aclk) begin
        lookup_t got, want;
        if (!aresetn) begin
            for (int i = 0; i < LINES; i++) begin
                valid_bits[i] <= 0;
                counters[i] <= 0;
                tags[i] <= 0;
            end
            lfsr <= ctlr_pkg::LFSR_SEED;
            blk_shift <= 0;
            set_bits <= 0;
            pol <= ctlr_pkg::POL_FIFO;
            fail_count <= 0;
            expected_lookups.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    ctlr_pkg::CFG_BLOCK_SIZE: blk_shift <= cfg_data[2:0];
                    ctlr_pkg::CFG_SET_COUNT: set_bits <= cfg_data[2:0];
                    ctlr_pkg::CFG_POLICY: pol <= cfg_data[1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) expected_lookups.push_back(predict_lookup(s_address));
            if (m_valid && m_ready) begin
                got = '{m_hit, m_set_index, m_way_index, m_evicted, m_block_number};
                if (expected_lookups.size() == 0) begin
                    if (fail_count < 10) $display("unexpected result %p", got);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_lookups.pop_front();
                    if (got !== want) begin
                        if (fail_count < 10) $display("mismatch: expected %p, got %p", want, got);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== tb/tb_top.sv =====
// Top of the testbench: clock, reset, stimulus, idling and the verdict.
`timescale 1ns / 1ps
module tb_top;

    logic        aclk, aresetn;
    logic        cfg_valid, cfg_ready;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;
    logic        s_valid, s_ready;
    logic [31:0] s_address;
    logic        m_valid, m_ready;
    logic        m_hit, m_evicted;
    logic [4:0]  m_set_index, m_way_index;
    logic [31:0] m_block_number;
    int          fail_count, pending;
    int          idle_cycles;
    int          stall_left;
    bit          quiet_tail, long_hold;
    logic [31:0] addr_pool [16];

    cache_tag_lookup_replacement_unit #(.LINES(32)) dut (.*);
    ctlr_checker #(.LINES(32)) chk (.*);

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // Write one register while the unit is idle; the caller drops valid afterwards
    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Offer one address, with an optional short gap first; valid stays up after the transfer
    task automatic send_access(input logic [31:0] addr);
        if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_address <= addr;
        s_valid <= 1;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drop the input and wait until every expected result has come back
    task automatic wait_results();
        s_valid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // Wait for every result, then let the unit settle before a register write
    task automatic drain();
        wait_results();
        repeat (150) @(posedge aclk);
    endtask

    task automatic configure(input int bs, input int sc, input int p);
        drain();
        write_reg(ctlr_pkg::CFG_BLOCK_SIZE, bs[7:0]);
        write_reg(ctlr_pkg::CFG_SET_COUNT, sc[7:0]);
        write_reg(ctlr_pkg::CFG_POLICY, p[7:0]);
        cfg_valid <= 0;
    endtask

    // Mostly reuse a small pool so sets fill, hit and evict
    function automatic logic [31:0] pick_address();
        if ($urandom_range(0, 9) < 8) return addr_pool[$urandom_range(0, 15)];
        return $urandom;
    endfunction

    // Receiver: short stall bursts, one long hold-off, none in the tail
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 0;
            stall_left <= 0;
        end else if (long_hold) begin
            m_ready <= 0;
        end else if (stall_left > 0) begin
            m_ready <= 0;
            stall_left <= stall_left - 1;
        end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            m_ready <= 0;
            stall_left <= $urandom_range(0, 2);
        end else begin
            m_ready <= 1;
        end
    end

    // Watchdog on cycles with no transfer
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        int p;
        aresetn = 0;
        cfg_valid = 0; cfg_index = 0; cfg_data = 0;
        s_valid = 0; s_address = 0;
        quiet_tail = 0; long_hold = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: reset settings, extremes of the address
        send_access(32'h0000_0000);
        send_access(32'hFFFF_FFFF);
        send_access(32'h0000_0000);
        send_access(32'hAAAA_5555);
        send_access(32'h5555_AAAA);
        // Direct mapped FIFO: conflicting blocks evict
        configure(0, 5, ctlr_pkg::POL_FIFO);
        send_access(32'h0000_0003);
        send_access(32'h0000_0023);
        send_access(32'h0000_0003);
        // Oversized set count and largest shift, LFU
        configure(7, 7, ctlr_pkg::POL_LFU);
        send_access(32'h8000_0000);
        send_access(32'h8000_007F);
        send_access(32'h0000_0080);
        // Random policy on a two-way set, forcing evictions
        configure(6, 4, ctlr_pkg::POL_RANDOM);
        for (int i = 0; i < 6; i++) send_access(i << 10);
        // LRU, same mapping kept (no flush)
        configure(6, 4, ctlr_pkg::POL_LRU);
        for (int i = 0; i < 6; i++) send_access((5 - i) << 10);

        // Random phases over many settings
        for (int ph = 0; ph < 10; ph++) begin
            p = ph % 4;
            configure($urandom_range(0, 7), $urandom_range(0, 7), p);
            for (int i = 0; i < 16; i++) addr_pool[i] = $urandom;
            if (ph == 9) quiet_tail = 1;
            for (int i = 0; i < 43; i++) begin
                if (ph == 2 && i == 5) begin
                    // Long hold-off on the result side while addresses keep coming
                    fork
                        begin
                            long_hold = 1;
                            repeat (300) @(posedge aclk);
                            long_hold = 0;
                        end
                    join_none
                end
                if (ph == 4 && i == 20) wait_results();
                send_access(pick_address());
            end
        end

        wait_results();
        repeat (100) @(posedge aclk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
